### src/rrs_pkg.sv
`default_nettype none

package rrs_pkg;

	// Default sizing of the process table.
	localparam int MAX_PROCS_DEF  = 64;
	localparam int BURST_BITS_DEF = 16;

	// Fixed field widths.
	localparam int QUANTUM_W = 16;
	localparam int CLOCK_W   = 22;
	localparam int REQ_W     = 2;
	localparam int BURST_W   = 16;
	localparam int PID_W     = 7;

	localparam logic [QUANTUM_W-1:0] QUANTUM_RESET = QUANTUM_W'(10);
	localparam logic [CLOCK_W-1:0]   CLOCK_MAX     = {CLOCK_W{1'b1}};

	// Request codes carried in req_type.
	typedef enum logic [REQ_W-1:0] {
		REQ_LOAD  = 2'd0,
		REQ_CLEAR = 2'd1,
		REQ_STEP  = 2'd2
	} req_t;

	// Scheduler sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_ADD,
		ST_FIN
	} state_t;

endpackage

`default_nettype wire

### src/rrs_if.sv
`default_nettype none

// Request channel: one load, clear or step request per transfer.
interface rrs_req_if;
	import rrs_pkg::*;

	logic                valid;
	logic                ready;
	logic [REQ_W-1:0]    req_type;
	logic [BURST_W-1:0]  burst_len;

	modport source (output valid, req_type, burst_len, input ready);
	modport sink (input valid, req_type, burst_len, output ready);
endinterface

// Response channel: one slot report per step request.
interface rrs_rsp_if;
	import rrs_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [PID_W-1:0]      proc_num;
	logic [QUANTUM_W-1:0]  ran_for;
	logic [CLOCK_W-1:0]    elapsed_time;
	logic                  finished;
	logic [CLOCK_W-1:0]    turnaround;
	logic [CLOCK_W-1:0]    waiting;
	logic                  all_done;

	modport source (output valid, proc_num, ran_for, elapsed_time, finished,
		turnaround, waiting, all_done, input ready);
	modport sink (input valid, proc_num, ran_for, elapsed_time, finished,
		turnaround, waiting, all_done, output ready);
endinterface

`default_nettype wire

### src/round_robin_schedule_stepper.sv
// Round-robin scheduling stepper.
// Requests arrive on cmd (valid/ready). A load request appends a process with
// the given burst time to the table, a clear request empties the table and the
// clock, and a step request runs the next unfinished process circularly for
// min(remaining, quantum or 1 if 0) and reports the slot on rsp (valid/ready).
// Loads and clears produce no response; a step always produces exactly one.
// The quantum is written through cfg_we/cfg_wdata; the user must write it only
// while the block is idle, which the block itself does not enforce. Load, clear
// and a step with nothing left to run need no scan. A scheduled step stays in
// ST_READ for each finished entry skipped on the way to the next runnable one
// (one RAM with a registered read, scanned one entry per cycle), then ST_ADD
// advances the clock, ST_FIN computes the wait; one entry is written back.
// A new request is taken once the previous step is done and the response
// register is empty or draining; a stalled rsp holds its report and blocks
// cmd. Reset clears the counters and the clock and restores a quantum of 10;
// the table contents need no clearing, since only loaded entries are read.
`default_nettype none

module round_robin_schedule_stepper #(
	parameter int MAX_PROCS  = rrs_pkg::MAX_PROCS_DEF,
	parameter int BURST_BITS = rrs_pkg::BURST_BITS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [rrs_pkg::QUANTUM_W-1:0]  cfg_wdata,
	rrs_req_if.sink                             cmd,
	rrs_rsp_if.source                           rsp
);
	import rrs_pkg::*;

	localparam int AW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
	localparam int CW = $clog2(MAX_PROCS + 1);
	localparam int RW = (BURST_BITS > QUANTUM_W) ? BURST_BITS : QUANTUM_W;
	localparam int SW = CLOCK_W + 1;
	localparam int WW = (BURST_BITS > CLOCK_W) ? BURST_BITS : CLOCK_W;
	localparam int EW = 2 * BURST_BITS;

	// Control state.
	state_t                 state_q, state_d;
	logic [QUANTUM_W-1:0]   quantum_q;
	logic [CW-1:0]          loaded_q;
	logic [CW-1:0]          unfinished_q;
	logic [AW-1:0]          next_q;
	logic [CLOCK_W-1:0]     clock_q;
	logic                   rsp_valid_q;

	// Step working registers.
	logic [AW-1:0]          slot_q;
	logic [QUANTUM_W-1:0]   run_q;
	logic                   fin_q;
	logic [BURST_BITS-1:0]  burst_q;

	// Response payload registers.
	logic [PID_W-1:0]       pid_q;
	logic [QUANTUM_W-1:0]   ran_q;
	logic [CLOCK_W-1:0]     elapsed_q;
	logic                   finished_q;
	logic [CLOCK_W-1:0]     turnaround_q;
	logic [CLOCK_W-1:0]     waiting_q;
	logic                   all_done_q;

	// RAM ports.
	logic                   ram_we;
	logic [AW-1:0]          ram_waddr;
	logic [EW-1:0]          ram_wdata;
	logic [AW-1:0]          ram_raddr;
	logic [EW-1:0]          ram_rdata;

	logic                   cmd_fire;
	logic                   rsp_set;
	logic                   table_empty;
	logic                   table_full;
	logic [BURST_BITS-1:0]  load_burst;
	logic [AW-1:0]          start_slot;
	logic [CW-1:0]          slot_inc;
	logic [AW-1:0]          wrap_slot;
	logic [BURST_BITS-1:0]  rem_rd;
	logic [BURST_BITS-1:0]  burst_rd;
	logic [QUANTUM_W-1:0]   q_eff;
	logic [QUANTUM_W-1:0]   run;
	logic [BURST_BITS-1:0]  rem_new;
	logic [SW-1:0]          clock_sum;
	logic [CLOCK_W-1:0]     clock_new;
	logic [CLOCK_W-1:0]     wait_val;

	// Each entry holds the burst time above the remaining time.
	rrs_ram #(
		.WIDTH (EW),
		.DEPTH (MAX_PROCS)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Request handshake and table status.
	assign cmd_fire    = cmd.valid && cmd.ready;
	assign cmd.ready   = (state_q == ST_IDLE) && (!rsp_valid_q || rsp.ready);
	assign table_empty = (unfinished_q == '0) || (loaded_q == '0);
	assign table_full  = (loaded_q >= CW'(MAX_PROCS));
	assign load_burst  = BURST_BITS'(cmd.burst_len);

	// Circular slot arithmetic.
	assign start_slot = (CW'(next_q) < loaded_q) ? next_q : '0;
	assign slot_inc   = CW'(slot_q) + CW'(1);
	assign wrap_slot  = (slot_inc >= loaded_q) ? '0 : slot_inc[AW-1:0];

	// Slice computation on the entry just read.
	assign rem_rd   = ram_rdata[BURST_BITS-1:0];
	assign burst_rd = ram_rdata[EW-1:BURST_BITS];
	assign q_eff    = (quantum_q == '0) ? QUANTUM_W'(1) : quantum_q;
	assign run      = (RW'(rem_rd) <= RW'(q_eff)) ? QUANTUM_W'(rem_rd) : q_eff;
	assign rem_new  = rem_rd - BURST_BITS'(run);

	// Saturating clock advance.
	assign clock_sum = SW'(clock_q) + SW'(run_q);
	assign clock_new = (clock_sum > SW'(CLOCK_MAX)) ? CLOCK_MAX : clock_sum[CLOCK_W-1:0];

	// Waiting time, clamped at zero.
	assign wait_val = (WW'(clock_q) >= WW'(burst_q))
		? CLOCK_W'(WW'(clock_q) - WW'(burst_q)) : '0;

	// Next state and RAM control.
	always_comb begin
		state_d   = state_q;
		ram_we    = 1'b0;
		ram_waddr = loaded_q[AW-1:0];
		ram_wdata = {load_burst, load_burst};
		ram_raddr = slot_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd_fire) begin
					if (cmd.req_type == REQ_LOAD && !table_full) begin
						ram_we = 1'b1;
					end else if (cmd.req_type == REQ_STEP && !table_empty) begin
						ram_raddr = start_slot;
						state_d   = ST_READ;
					end
				end
			end
			ST_READ: begin
				if (rem_rd == '0) begin
					ram_raddr = wrap_slot;
				end else begin
					ram_we    = 1'b1;
					ram_waddr = slot_q;
					ram_wdata = {burst_rd, rem_new};
					state_d   = ST_ADD;
				end
			end
			ST_ADD: begin
				state_d = ST_FIN;
			end
			ST_FIN: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// A report is raised by a completed step or a step on an exhausted table.
	assign rsp_set = (state_q == ST_FIN)
		|| (cmd_fire && cmd.req_type == REQ_STEP && table_empty);

	// Response valid: set on a new report, cleared when the report transfers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_set) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// Counters, clock and quantum.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quantum_q    <= QUANTUM_RESET;
			loaded_q     <= '0;
			unfinished_q <= '0;
			next_q       <= '0;
			clock_q      <= '0;
		end else begin
			if (cfg_we) begin
				quantum_q <= cfg_wdata;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd_fire) begin
						case (cmd.req_type)
							REQ_LOAD: begin
								if (!table_full) begin
									loaded_q <= loaded_q + CW'(1);
									if (load_burst != '0) begin
										unfinished_q <= unfinished_q + CW'(1);
									end
								end
							end
							REQ_CLEAR: begin
								loaded_q     <= '0;
								unfinished_q <= '0;
								next_q       <= '0;
								clock_q      <= '0;
							end
							default: begin
							end
						endcase
					end
				end
				ST_READ: begin
					if (rem_rd != '0) begin
						next_q <= wrap_slot;
						if (rem_new == '0 && unfinished_q != '0) begin
							unfinished_q <= unfinished_q - CW'(1);
						end
					end
				end
				ST_ADD: begin
					clock_q <= clock_new;
				end
				default: begin
				end
			endcase
		end
	end

	// Step working registers and response payload.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				slot_q <= start_slot;
				if (cmd_fire && cmd.req_type == REQ_STEP && table_empty) begin
					pid_q        <= '0;
					ran_q        <= '0;
					elapsed_q    <= clock_q;
					finished_q   <= 1'b0;
					turnaround_q <= '0;
					waiting_q    <= '0;
					all_done_q   <= 1'b1;
				end
			end
			ST_READ: begin
				if (rem_rd == '0) begin
					slot_q <= wrap_slot;
				end else begin
					run_q   <= run;
					fin_q   <= (rem_new == '0);
					burst_q <= burst_rd;
				end
			end
			ST_FIN: begin
				pid_q        <= PID_W'(CW'(slot_q) + CW'(1));
				ran_q        <= run_q;
				elapsed_q    <= clock_q;
				finished_q   <= fin_q;
				turnaround_q <= fin_q ? clock_q : '0;
				waiting_q    <= fin_q ? wait_val : '0;
				all_done_q   <= 1'b0;
			end
			default: begin
			end
		endcase
	end

	// Response outputs.
	assign rsp.valid        = rsp_valid_q;
	assign rsp.proc_num     = pid_q;
	assign rsp.ran_for      = ran_q;
	assign rsp.elapsed_time = elapsed_q;
	assign rsp.finished     = finished_q;
	assign rsp.turnaround   = turnaround_q;
	assign rsp.waiting      = waiting_q;
	assign rsp.all_done     = all_done_q;

	// The unfinished count never exceeds the number of loaded entries.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		unfinished_q <= loaded_q)
		else $error("unfinished count exceeds loaded count");

	// A scan only runs while some process is still unfinished.
	a_scan_live: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ) |-> (unfinished_q != '0 && loaded_q != '0))
		else $error("table scan with no runnable process");

	// A step on an exhausted table reports all_done in the next cycle.
	a_all_done: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_fire && cmd.req_type == REQ_STEP && table_empty)
		|=> (rsp.valid && rsp.all_done && rsp.proc_num == '0))
		else $error("missing all_done report");

	// The scan index always points inside the loaded part of the table.
	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ) |-> (CW'(slot_q) < loaded_q))
		else $error("scan slot beyond loaded entries");

	// A request is only taken when the response register can accept a report.
	a_rsp_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_fire |-> (!rsp.valid || rsp.ready))
		else $error("request taken while response is stalled");

endmodule

`default_nettype wire

### src/rrs_ram.sv
`default_nettype none

// Simple dual-port RAM: one write port, one read port with registered data.
module rrs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                      clk,
	input  wire logic                      we,
	input  wire logic [$clog2(DEPTH)-1:0]  waddr,
	input  wire logic [WIDTH-1:0]          wdata,
	input  wire logic [$clog2(DEPTH)-1:0]  raddr,
	output logic      [WIDTH-1:0]          rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire
